### rtl/spbf_pkg.sv
// Package for the spectrum peak bin finder: frame geometry, field widths,
// controller state type. No dependencies.
package spbf_pkg;

    // Frame geometry: POINTS-point transform, half of it arrives as bins
    localparam int PTS_LOG2 = 8;
    localparam int POINTS   = 1 << PTS_LOG2;
    localparam int BINS     = POINTS / 2;
    localparam int BIN_W    = PTS_LOG2 - 1;

    // Field widths
    localparam int DATA_W = 16;
    localparam int SR_W   = 22;
    localparam int MAG_W  = 17;
    localparam int IDX_W  = 7;
    localparam int FREQ_W = 21;

    // Power and root datapath
    localparam int SQ_W       = 2 * DATA_W - 1;
    localparam int PW_W       = 2 * DATA_W;
    localparam int RAD_W      = 2 * MAG_W;
    localparam int REM_W      = MAG_W + 3;
    localparam int ROOT_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    localparam logic [SR_W-1:0] SR_RESET = SR_W'(44800);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE,
        ST_EMIT
    } t_state;

endpackage

### rtl/spbf_if.sv
// Handshake channels of the spectrum peak bin finder: config, bin, result.
// Depends on spbf_pkg.

interface spbf_cfg_if import spbf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spbf_bin_if import spbf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] real_part;
    logic signed [DATA_W-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface spbf_res_if import spbf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MAG_W-1:0]  magnitude;
    logic [IDX_W-1:0]  bin_index;
    logic              frame_done;
    logic [IDX_W-1:0]  peak_bin;
    logic [MAG_W-1:0]  peak_magnitude;
    logic [FREQ_W-1:0] peak_freq;

    modport source (output valid, output magnitude, output bin_index, output frame_done,
                    output peak_bin, output peak_magnitude, output peak_freq, input ready);
    modport sink   (input valid, input magnitude, input bin_index, input frame_done,
                    input peak_bin, input peak_magnitude, input peak_freq, output ready);
endinterface

### rtl/spbf_isqrt.sv
// Digit-serial integer square root: two radicand bits per cycle, one root bit.
// Depends on spbf_pkg.
module spbf_isqrt import spbf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    logic             r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_root;

    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fits;

    // One restoring step: bring down two bits, try (root<<2)|1
    always_comb begin
        cur   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial = REM_W'({r_root, 2'b01});
        fits  = (cur >= trial);
    end

    // Control: step counter runs from start until done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Datapath: radicand shifts out two bits per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? (cur - trial) : cur;
            r_root <= {r_root[MAG_W-2:0], fits};
        end
    end

    // Done on the final step; root is complete the cycle after
    assign o_done = r_busy && (r_cnt == STEP_W'(ROOT_STEPS - 1));
    assign o_root = r_root;

endmodule

### rtl/spectrum_peak_bin_finder.sv
// Spectrum peak bin finder top level: per-bin magnitude and frame peak search.
// Depends on spbf_pkg, spbf_if (channels) and spbf_isqrt.

// Takes FFT bins 0 to POINTS/2-1 one beat at a time and returns one result
// beat per bin: floor(sqrt(re^2+im^2)) for bin 0, floor(2*sqrt(re^2+im^2))
// for the others, plus on the last bin of the frame the first strongest bin
// above bin 0, its magnitude and floor(bin*sample_rate/POINTS). A bin goes
// through its two squares in turn on a single shared 16x16 multiplier, the
// bit-serial square root (one root bit a cycle), the peak update and the
// load of the output register, which waits while that register holds an
// untaken result; only then is the next bin accepted. A finished result
// waits in the output register while the next bin is accepted and worked
// on. sample_rate arrives through the config channel, which is always ready.
module spectrum_peak_bin_finder import spbf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spbf_cfg_if.sink          i_cfg,
    spbf_bin_if.sink          i_bin,
    spbf_res_if.source        o_res
);

    t_state r_state, n_state;

    logic                     r_out_valid;
    logic [SR_W-1:0]          r_sample_rate;
    logic [BIN_W-1:0]         r_bin;
    logic [MAG_W-1:0]         r_best_mag;
    logic [BIN_W-1:0]         r_best_bin;
    logic [SQ_W-1:0]          r_sq;
    logic signed [DATA_W-1:0] r_im;

    logic [MAG_W-1:0]  r_o_mag;
    logic [IDX_W-1:0]  r_o_idx;
    logic              r_o_done;
    logic [IDX_W-1:0]  r_o_pbin;
    logic [MAG_W-1:0]  r_o_pmag;
    logic [FREQ_W-1:0] r_o_freq;

    logic bin_ready, sq_start, upd_en, emit_en, out_free, last_bin, sq_done;
    logic signed [DATA_W-1:0]  mul_op;
    logic signed [PW_W-1:0]    mul_full;
    logic [PW_W-1:0]           pw;
    logic [RAD_W-1:0]          radicand;
    logic [MAG_W-1:0]          root;
    logic [BIN_W+SR_W-1:0]     prod;
    logic [FREQ_W-1:0]         freq;

    // Config: always ready
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
        end else if (i_cfg.valid) begin
            r_sample_rate <= i_cfg.data;
        end
    end

    // Shared squarer: real part at acceptance, imaginary part next cycle
    assign mul_op   = (r_state == ST_IDLE) ? i_bin.real_part : r_im;
    assign mul_full = mul_op * mul_op;
    assign pw       = PW_W'(r_sq) + PW_W'(mul_full[SQ_W-1:0]);
    // Non-DC bins take sqrt(4*pw) for the doubled magnitude
    assign radicand = (r_bin == '0) ? RAD_W'(pw) : {pw, 2'b00};

    spbf_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (radicand),
        .o_done     (sq_done),
        .o_root     (root)
    );

    assign last_bin = (r_bin == BIN_W'(BINS - 1));
    assign out_free = !r_out_valid || o_res.ready;

    // Frequency from the (already updated) peak bin
    assign prod = (BIN_W+SR_W)'(r_best_bin) * (BIN_W+SR_W)'(r_sample_rate);
    assign freq = FREQ_W'(prod >> PTS_LOG2);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state   = r_state;
        bin_ready = 1'b0;
        sq_start  = 1'b0;
        upd_en    = 1'b0;
        emit_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                bin_ready = 1'b1;
                if (i_bin.valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                sq_start = 1'b1;
                n_state  = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                upd_en  = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_bin.ready = bin_ready;

    // Capture first square and imaginary part on the input beat
    always_ff @(posedge i_clk) begin
        if (bin_ready && i_bin.valid) begin
            r_sq <= mul_full[SQ_W-1:0];
            r_im <= i_bin.imag_part;
        end
    end

    // Frame state: bin counter and running peak (strict compare, DC excluded)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin      <= '0;
            r_best_mag <= '0;
            r_best_bin <= '0;
        end else if (upd_en) begin
            if ((r_bin != '0) && (root > r_best_mag)) begin
                r_best_mag <= root;
                r_best_bin <= r_bin;
            end
        end else if (emit_en) begin
            if (last_bin) begin
                r_bin      <= '0;
                r_best_mag <= '0;
                r_best_bin <= '0;
            end else begin
                r_bin <= r_bin + 1'b1;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_en) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; peak fields only on the last bin
    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_o_mag  <= root;
            r_o_idx  <= IDX_W'(r_bin);
            r_o_done <= last_bin;
            r_o_pbin <= last_bin ? IDX_W'(r_best_bin) : '0;
            r_o_pmag <= last_bin ? r_best_mag : '0;
            r_o_freq <= last_bin ? freq : '0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.magnitude      = r_o_mag;
    assign o_res.bin_index      = r_o_idx;
    assign o_res.frame_done     = r_o_done;
    assign o_res.peak_bin       = r_o_pbin;
    assign o_res.peak_magnitude = r_o_pmag;
    assign o_res.peak_freq      = r_o_freq;

endmodule

### rtl/spbf_checker.sv
// Port-level checks for the spectrum peak bin finder, bound to the top level.
// Depends on spbf_pkg and spectrum_peak_bin_finder.
module spbf_checker import spbf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [MAG_W-1:0]  i_res_magnitude,
    input logic [IDX_W-1:0]  i_res_bin_index,
    input logic              i_res_frame_done,
    input logic [IDX_W-1:0]  i_res_peak_bin,
    input logic [MAG_W-1:0]  i_res_peak_magnitude,
    input logic [FREQ_W-1:0] i_res_peak_freq
);

    // Stalled result beat stays and holds its magnitude, bin index and peak frequency
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_magnitude)
            && $stable(i_res_bin_index) && $stable(i_res_peak_freq))
        else $error("result beat changed while stalled");

    // Frame end only on the last bin
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_frame_done |-> i_res_bin_index == IDX_W'(BINS - 1))
        else $error("frame_done on a bin other than the last");

    // Peak fields are zero mid-frame
    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_frame_done |->
            i_res_peak_bin == '0 && i_res_peak_magnitude == '0 && i_res_peak_freq == '0)
        else $error("peak fields set before the last bin");

    // DC is never the peak: peak bin zero exactly when no magnitude exceeded zero
    a_peak_dc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_frame_done |->
            (i_res_peak_bin == '0) == (i_res_peak_magnitude == '0))
        else $error("peak bin and peak magnitude disagree");

endmodule

bind spectrum_peak_bin_finder spbf_checker u_spbf_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_magnitude      (o_res.magnitude),
    .i_res_bin_index      (o_res.bin_index),
    .i_res_frame_done     (o_res.frame_done),
    .i_res_peak_bin       (o_res.peak_bin),
    .i_res_peak_magnitude (o_res.peak_magnitude),
    .i_res_peak_freq      (o_res.peak_freq)
);

### tb/tb.sv
`timescale 1ns / 100ps

// Self-checking testbench for spectrum_peak_bin_finder: drives whole FFT frames,
// predicts every result beat with its own magnitude and peak model, checks each beat.
// Depends on spbf_pkg, the spbf_if channel interfaces and the RTL top level.

module tb;
    import spbf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PCT      = 11;
    localparam int NO_TYPED      = -1;
    localparam int NO_HOLD       = -1;
    localparam int DIR_ROWS      = 16;

    // One result beat as the block presents it
    typedef struct packed {
        logic [MAG_W-1:0]  magnitude;
        logic [IDX_W-1:0]  bin_index;
        logic              frame_done;
        logic [IDX_W-1:0]  peak_bin;
        logic [MAG_W-1:0]  peak_magnitude;
        logic [FREQ_W-1:0] peak_freq;
    } t_bin_result;

    // Shapes of generated frames
    typedef enum int {
        FR_NOISE,
        FR_TONE,
        FR_SILENT,
        FR_TIE,
        FR_EDGE,
        FR_TINY
    } t_frame_kind;

    typedef struct {
        int re;
        int im;
        int mag;
    } t_dir_row;

    // Directed opening of the first frame after reset; mag of NO_TYPED
    // means the beat is checked against the predictor only
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{-32768, -32768, 46340},     // DC at full scale, half-scale magnitude
        '{-32768, -32768, 92681},     // largest possible bin, becomes the peak
        '{ 32767,  32767, 92679},
        '{     0,      0,     0},
        '{-32768,      0, 65536},
        '{     0,  32767, 65534},
        '{     3,      4,    10},
        '{    -1,     -1,     2},
        '{     1,      0,     2},
        '{-32768, -32768, 92681},     // equal to the peak, first one must stay
        '{     0, -32768, 65536},
        '{ 32767, -32768, 92680},
        '{ 12345,  -6789, NO_TYPED},
        '{-20000,  31000, NO_TYPED},
        '{ 32767,     -1, NO_TYPED},
        '{ -1234,  -4321, NO_TYPED}
    };

    logic clk;
    logic rst_n;

    spbf_cfg_if cfg_ch ();
    spbf_bin_if bin_ch ();
    spbf_res_if res_ch ();

    spectrum_peak_bin_finder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_bin   (bin_ch),
        .o_res   (res_ch)
    );

    // Predictor state
    int unsigned       mdl_bin;
    longint unsigned   mdl_best_mag;
    int unsigned       mdl_best_bin;
    logic [SR_W-1:0]   mdl_rate;

    t_bin_result awaited_results [$];

    // Stimulus and bookkeeping
    int  next_bin;
    int  typed_mag;
    bit  gaps_on;
    bit  stall_req;
    int  hold_left;
    int  cycle_cnt;
    int  mismatches;
    int  bins_sent;
    int  beats_checked;
    int  frames_seen;
    int  rate_writes;

    // Clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Integer square root, floor, two bits of radicand per step
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - root - probe;
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Magnitude of one bin plus the frame peak on the last bin; advances the frame
    function automatic t_bin_result compute_bin_result(input logic signed [DATA_W-1:0] re,
                                                       input logic signed [DATA_W-1:0] im);
        t_bin_result     r;
        longint unsigned pw;
        longint unsigned mag;
        longint unsigned hz;
        r  = '0;
        pw = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        if (mdl_bin == 0) begin
            mag = floor_sqrt(pw);
        end else begin
            mag = floor_sqrt(pw * 4);
            if (mag > mdl_best_mag) begin
                mdl_best_mag = mag;
                mdl_best_bin = mdl_bin;
            end
        end
        r.magnitude = mag[MAG_W-1:0];
        r.bin_index = IDX_W'(mdl_bin);
        if (mdl_bin >= BINS - 1) begin
            hz               = (64'(mdl_best_bin) * 64'(mdl_rate)) / POINTS;
            r.frame_done     = 1'b1;
            r.peak_bin       = IDX_W'(mdl_best_bin);
            r.peak_magnitude = mdl_best_mag[MAG_W-1:0];
            r.peak_freq      = hz[FREQ_W-1:0];
            mdl_bin          = 0;
            mdl_best_mag     = 0;
            mdl_best_bin     = 0;
        end else begin
            mdl_bin = mdl_bin + 1;
        end
        return r;
    endfunction

    // Compare one result beat against the oldest awaited one
    task automatic check_result();
        t_bin_result got;
        t_bin_result want;
        got.magnitude      = res_ch.magnitude;
        got.bin_index      = res_ch.bin_index;
        got.frame_done     = res_ch.frame_done;
        got.peak_bin       = res_ch.peak_bin;
        got.peak_magnitude = res_ch.peak_magnitude;
        got.peak_freq      = res_ch.peak_freq;
        if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result beat: bin %0d mag %0d", got.bin_index,
                         got.magnitude);
        end else begin
            want = awaited_results.pop_front();
            beats_checked++;
            if (want.frame_done)
                frames_seen++;
            if (got.magnitude !== want.magnitude || got.bin_index !== want.bin_index ||
                got.frame_done !== want.frame_done || got.peak_bin !== want.peak_bin ||
                got.peak_magnitude !== want.peak_magnitude ||
                got.peak_freq !== want.peak_freq) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch at beat %0d:", beats_checked);
                    $display("  exp mag %0d bin %0d done %0b peak %0d pmag %0d freq %0d",
                             want.magnitude, want.bin_index, want.frame_done,
                             want.peak_bin, want.peak_magnitude, want.peak_freq);
                    $display("  got mag %0d bin %0d done %0b peak %0d pmag %0d freq %0d",
                             got.magnitude, got.bin_index, got.frame_done,
                             got.peak_bin, got.peak_magnitude, got.peak_freq);
                end
            end
        end
    endtask

    // Watch all three channels at the rising edge
    always @(posedge clk) begin : watch
        t_bin_result want;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                mdl_rate = cfg_ch.data;
                rate_writes++;
            end
            if (bin_ch.valid && bin_ch.ready) begin
                want = compute_bin_result(bin_ch.real_part, bin_ch.imag_part);
                if (typed_mag != NO_TYPED)
                    want.magnitude = MAG_W'(typed_mag);
                awaited_results.push_back(want);
                bins_sent++;
            end
            if (res_ch.valid && res_ch.ready)
                check_result();
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (stall_req) begin
            stall_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycle_cnt,
                     awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one bin beat and wait for it to be taken
    task automatic send_bin(input int re, input int im, input int typed);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            bin_ch.valid <= 1'b0;
            @(negedge clk);
        end
        bin_ch.valid     <= 1'b1;
        bin_ch.real_part <= DATA_W'(re);
        bin_ch.imag_part <= DATA_W'(im);
        typed_mag = typed;
        @(posedge clk);
        while (!bin_ch.ready)
            @(posedge clk);
        next_bin = (next_bin + 1) % BINS;
    endtask

    function automatic int rand_span(input int a);
        return int'($urandom_range(2 * a)) - a;
    endfunction

    function automatic int rand_full();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Strong component of either sign, at least well above the background
    function automatic int rand_strong();
        int v;
        v = int'($urandom_range(32767, 20000));
        return ($urandom_range(1) != 0) ? -v : v;
    endfunction

    // Send bins up to the end of the current frame in the given shape
    task automatic run_frame(input t_frame_kind kind, input int hold_at);
        int peak;
        int tie_a;
        int tie_b;
        int t_re;
        int t_im;
        int re;
        int im;
        peak = $urandom_range(BINS - 1, 1);
        if (kind == FR_EDGE)
            peak = ($urandom_range(1) != 0) ? BINS - 1 : 1;
        tie_a = $urandom_range(BINS - 2, 1);
        tie_b = $urandom_range(BINS - 1, tie_a + 1);
        t_re  = rand_span(30000);
        t_im  = rand_span(30000);
        do begin
            if (next_bin == hold_at)
                stall_req = 1'b1;
            re = rand_full();
            im = rand_full();
            if (next_bin != 0) begin
                case (kind)
                    FR_TONE, FR_EDGE: begin
                        if (next_bin == peak) begin
                            re = rand_strong();
                            im = rand_strong();
                        end else begin
                            re = rand_span(2000);
                            im = rand_span(2000);
                        end
                    end
                    FR_SILENT: begin
                        re = 0;
                        im = 0;
                    end
                    // same magnitude twice, rotated by a quarter turn
                    FR_TIE: begin
                        if (next_bin == tie_a) begin
                            re = t_re;
                            im = t_im;
                        end else if (next_bin == tie_b) begin
                            re = -t_im;
                            im = t_re;
                        end else begin
                            re = rand_span(500);
                            im = rand_span(500);
                        end
                    end
                    FR_TINY: begin
                        re = rand_span(1);
                        im = rand_span(1);
                    end
                    default: ;
                endcase
            end
            send_bin(re, im, NO_TYPED);
        end while (next_bin != 0);
    endtask

    // Wait until the block has drained
    task automatic settle();
        @(negedge clk);
        bin_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [SR_W-1:0] rate);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= rate;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        rst_n            = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        bin_ch.valid     = 1'b0;
        bin_ch.real_part = '0;
        bin_ch.imag_part = '0;
        res_ch.ready     = 1'b0;
        mdl_bin          = 0;
        mdl_best_mag     = 0;
        mdl_best_bin     = 0;
        mdl_rate         = SR_RESET;
        next_bin         = 0;
        typed_mag        = NO_TYPED;
        gaps_on          = 1'b1;
        stall_req        = 1'b0;
        hold_left        = 0;
        cycle_cnt        = 0;
        mismatches       = 0;
        bins_sent        = 0;
        beats_checked    = 0;
        frames_seen      = 0;
        rate_writes      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First frame at the reset sample rate: directed rows, then noise
        for (int row = 0; row < DIR_ROWS; row++)
            send_bin(dir_rows[row].re, dir_rows[row].im, dir_rows[row].mag);
        run_frame(FR_NOISE, NO_HOLD);

        settle();
        write_rate('1);
        run_frame(FR_TONE, NO_HOLD);

        // Long output hold-off while bins keep coming
        settle();
        write_rate(SR_W'(1));
        run_frame(FR_SILENT, 40);

        // Rate zero, and a frame with no idling on either side
        settle();
        write_rate('0);
        gaps_on = 1'b0;
        run_frame(FR_TIE, NO_HOLD);
        settle();
        gaps_on = 1'b1;

        write_rate(SR_W'(4000000));
        run_frame(FR_EDGE, NO_HOLD);

        settle();
        write_rate(SR_W'($urandom_range(4194303, 1)));
        run_frame(FR_TINY, NO_HOLD);

        settle();
        write_rate(SR_W'($urandom_range(4194303, 1)));
        run_frame(t_frame_kind'($urandom_range(int'(FR_TINY))), NO_HOLD);

        settle();
        write_rate(SR_W'(44800));
        run_frame(FR_EDGE, NO_HOLD);
        settle();

        $display("checked %0d result beats for %0d bins, %0d full frames", beats_checked,
                 bins_sent, frames_seen);
        $display("%0d sample rate writes from zero to full scale, one %0d-cycle output hold",
                 rate_writes, HOLD_CYCLES);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     awaited_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/spbf_pkg.sv
rtl/spbf_if.sv
rtl/spbf_isqrt.sv
rtl/spectrum_peak_bin_finder.sv
rtl/spbf_checker.sv
tb/tb.sv
